/* hw/rtl/buzzer_melody_sequencer_macros.svh */
// ---------------------------------------------------------------------------
// buzzer melody sequencer assertion macros
// shorthand for clocked assertions on aclk, disabled while aresetn is low
// ---------------------------------------------------------------------------
`ifndef BUZZER_MELODY_SEQUENCER_MACROS_SVH
`define BUZZER_MELODY_SEQUENCER_MACROS_SVH

// expression holds at every edge out of reset
`define BMS_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BMS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define BMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/bms_pkg.sv */
// ---------------------------------------------------------------------------
// bms_pkg
// types, score rom and pitch tables for the buzzer melody sequencer
// ---------------------------------------------------------------------------
package bms_pkg;

    localparam int SCORE_WORDS = 128;
    localparam int SCORE_AW    = $clog2(SCORE_WORDS);

    localparam int TICK_W  = 26;
    localparam int WAVE_W  = 16;
    localparam int IDX_W   = 7;
    localparam int SONG_W  = 2;
    localparam int PITCH_W = 4;
    localparam int DUR_W   = 4;
    localparam int POS_W   = 6;
    localparam int ADDR_W  = 8;
    localparam int PROD_W  = TICK_W + DUR_W;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;
    localparam logic [TICK_W-1:0] TICK_ONE = TICK_W'(1);

    localparam logic [SONG_W-1:0] SONG_FALLBACK = SONG_W'(3);

    // configuration register indexes
    localparam logic CFG_IDX_UNIT = 1'b0;
    localparam logic CFG_IDX_REST = 1'b1;

    typedef enum logic [1:0] {
        PH_DECIDE = 2'd0,
        PH_TONE   = 2'd1,
        PH_REST   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [TICK_W-1:0] unit_ticks;
        logic [TICK_W-1:0] rest_ticks;
    } cfg_t;

    typedef struct packed {
        logic               pwm_level;
        logic               tone_on;
        logic [PITCH_W-1:0] note_number;
        logic [POS_W-1:0]   note_position;
    } result_t;

    // high nibble duration, low nibble pitch
    localparam logic [7:0] SCORE_ROM [SCORE_WORDS] = '{
        // song 1
        8'h41, 8'h42, 8'h43, 8'h41, 8'h41, 8'h42, 8'h43, 8'h41,
        8'h43, 8'h44, 8'h85, 8'h43, 8'h44, 8'h85,
        8'h35, 8'h16, 8'h35, 8'h14, 8'h43, 8'h41, 8'h35, 8'h16,
        8'h35, 8'h14, 8'h43, 8'h41,
        8'h41, 8'h48, 8'h81, 8'h41, 8'h48, 8'h81,
        // song 2
        8'h26, 8'h25, 8'h23, 8'h25, 8'h26, 8'h26, 8'h26, 8'h25,
        8'h23, 8'h25, 8'h26, 8'h26, 8'h26, 8'h25, 8'h23, 8'h25,
        8'h26, 8'h26, 8'h26, 8'h25, 8'h23, 8'h25, 8'h26, 8'h26,
        8'h26, 8'h25, 8'h23, 8'h25, 8'h26, 8'h26, 8'h26, 8'h25,
        8'h23, 8'h25, 8'h26, 8'h26, 8'h26, 8'h25, 8'h23, 8'h25,
        8'h26, 8'h26, 8'h26, 8'h25, 8'h23, 8'h25, 8'h26, 8'h26,
        8'h26, 8'h25, 8'h23, 8'h25, 8'h26, 8'h26, 8'h26, 8'h25,
        8'h23, 8'h25, 8'h26, 8'h26, 8'h26, 8'h25, 8'h23, 8'h25,
        // song 3
        8'h45, 8'h45, 8'h46, 8'h46, 8'h45, 8'h45, 8'h43,
        8'h45, 8'h45, 8'h46, 8'h46, 8'h45, 8'h45, 8'h43,
        8'h45, 8'h45, 8'h46, 8'h46, 8'h45, 8'h45, 8'h43,
        8'h45, 8'h45, 8'h46, 8'h46, 8'h45, 8'h45, 8'h43,
        // unused tail
        8'h00, 8'h00, 8'h00, 8'h00
    };

    function automatic logic [7:0] score_word(input logic [ADDR_W-1:0] addr);
        logic [7:0] w;
        w = 8'h00;
        if (int'(addr) < SCORE_WORDS) begin
            w = SCORE_ROM[addr[SCORE_AW-1:0]];
        end
        return w;
    endfunction

    function automatic logic [WAVE_W-1:0] pitch_divisor(input logic [PITCH_W-1:0] p);
        logic [WAVE_W-1:0] d;
        case (p)
            4'd1:    d = 16'd38223;
            4'd2:    d = 16'd34052;
            4'd3:    d = 16'd30338;
            4'd4:    d = 16'd28635;
            4'd5:    d = 16'd25511;
            4'd6:    d = 16'd22728;
            4'd7:    d = 16'd20249;
            4'd8:    d = 16'd51021;
            default: d = 16'd0;
        endcase
        return d;
    endfunction

    function automatic logic [ADDR_W-1:0] song_base(input logic [SONG_W-1:0] s);
        logic [ADDR_W-1:0] b;
        case (s)
            2'd1:    b = 8'd0;
            2'd2:    b = 8'd32;
            default: b = 8'd96;
        endcase
        return b;
    endfunction

    function automatic logic [IDX_W-1:0] song_len(input logic [SONG_W-1:0] s);
        logic [IDX_W-1:0] n;
        case (s)
            2'd1:    n = 7'd32;
            2'd2:    n = 7'd64;
            default: n = 7'd28;
        endcase
        return n;
    endfunction

endpackage

/* hw/rtl/bms_seq_core.sv */
// ---------------------------------------------------------------------------
// bms_seq_core
// sequencer state and combinational next-state logic, one tick per beat
// ---------------------------------------------------------------------------
`include "buzzer_melody_sequencer_macros.svh"

module bms_seq_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic                          play_enable,
    input  logic [bms_pkg::SONG_W-1:0]    song_select,
    input  bms_pkg::cfg_t                 cfg,
    output bms_pkg::result_t              result
);

    bms_pkg::phase_t                 phase_reg, phase_next;
    logic [bms_pkg::TICK_W-1:0]      rest_count_reg, rest_count_next;
    logic [bms_pkg::TICK_W-1:0]      tone_count_reg, tone_count_next;
    logic [bms_pkg::WAVE_W-1:0]      wave_reg, wave_next;
    logic [bms_pkg::WAVE_W-1:0]      div_reg, div_next;
    logic [bms_pkg::PITCH_W-1:0]     pitch_reg, pitch_next;
    logic [bms_pkg::IDX_W-1:0]       note_idx_reg, note_idx_next;
    logic [bms_pkg::SONG_W-1:0]      playing_song_reg, playing_song_next;
    logic [bms_pkg::SONG_W-1:0]      previous_song_reg, previous_song_next;

    logic [bms_pkg::SONG_W-1:0]      sel;
    logic                            start, boundary, evaluate;
    logic                            end_pass, song_change;
    logic [bms_pkg::SONG_W-1:0]      eff_song;
    logic [bms_pkg::IDX_W-1:0]       eff_idx;

    logic [7:0]                      word;
    logic [bms_pkg::PROD_W-1:0]      prod;
    logic [bms_pkg::TICK_W-1:0]      tone_len, rest_len;
    logic                            new_tone, new_rest;
    logic [bms_pkg::WAVE_W-1:0]      div_cur, wave_cur, wave_inc;
    logic [bms_pkg::PITCH_W-1:0]     pitch_cur;
    logic [bms_pkg::TICK_W-1:0]      tone_cnt_cur, rest_cnt_cur;

    assign sel = (song_select == '0) ? bms_pkg::SONG_FALLBACK : song_select;

    // next state: pass start, note boundary or hold
    always_comb begin
        start    = 1'b0;
        boundary = 1'b0;
        unique case (phase_reg)
            bms_pkg::PH_TONE: begin
                boundary = (tone_count_reg == '0);
            end
            bms_pkg::PH_REST: begin
                start = (rest_count_reg == '0);
            end
            default: begin
                start = 1'b1;
            end
        endcase
        evaluate = start || boundary;

        eff_song = (start && play_enable) ? sel : playing_song_reg;
        if (start) begin
            eff_idx = play_enable ? '0 : note_idx_reg;
        end else if (boundary) begin
            eff_idx = note_idx_reg + bms_pkg::IDX_W'(1);
        end else begin
            eff_idx = note_idx_reg;
        end

        end_pass    = (eff_idx >= bms_pkg::song_len(eff_song)) || !play_enable;
        song_change = (sel != previous_song_reg);

        phase_next         = phase_reg;
        previous_song_next = previous_song_reg;
        if (evaluate) begin
            if (end_pass) begin
                phase_next = bms_pkg::PH_REST;
            end else if (song_change) begin
                phase_next         = bms_pkg::PH_REST;
                previous_song_next = sel;
            end else begin
                phase_next = bms_pkg::PH_TONE;
            end
        end
        playing_song_next = eff_song;
        note_idx_next     = eff_idx;
    end

    // counters, wave and result for this tick
    always_comb begin
        word     = bms_pkg::score_word(bms_pkg::song_base(eff_song) +
                                       bms_pkg::ADDR_W'(eff_idx));
        prod     = bms_pkg::PROD_W'(word[7:4]) * bms_pkg::PROD_W'(cfg.unit_ticks);
        tone_len = (prod[bms_pkg::PROD_W-1:bms_pkg::TICK_W] != '0) ? bms_pkg::TICK_MAX
                                                                    : prod[bms_pkg::TICK_W-1:0];
        if (tone_len == '0) begin
            tone_len = bms_pkg::TICK_ONE;
        end
        rest_len = (cfg.rest_ticks == '0) ? bms_pkg::TICK_ONE : cfg.rest_ticks;

        new_tone = evaluate && (phase_next == bms_pkg::PH_TONE);
        new_rest = evaluate && (phase_next == bms_pkg::PH_REST);

        div_cur      = new_tone ? bms_pkg::pitch_divisor(word[3:0]) : div_reg;
        wave_cur     = new_tone ? '0 : wave_reg;
        pitch_cur    = new_tone ? word[3:0] : pitch_reg;
        tone_cnt_cur = new_tone ? tone_len : tone_count_reg;
        rest_cnt_cur = new_rest ? rest_len : rest_count_reg;

        wave_inc        = wave_cur + bms_pkg::WAVE_W'(1);
        div_next        = div_cur;
        pitch_next      = pitch_cur;
        wave_next       = wave_reg;
        tone_count_next = tone_count_reg;
        rest_count_next = rest_count_reg;

        if (phase_next == bms_pkg::PH_TONE) begin
            result.pwm_level     = (wave_cur < (div_cur >> 1));
            result.tone_on       = 1'b1;
            result.note_number   = pitch_cur;
            result.note_position = eff_idx[bms_pkg::POS_W-1:0];
            wave_next            = (wave_inc >= div_cur) ? '0 : wave_inc;
            tone_count_next      = tone_cnt_cur - bms_pkg::TICK_ONE;
        end else begin
            result          = '0;
            rest_count_next = rest_cnt_cur - bms_pkg::TICK_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= bms_pkg::PH_DECIDE;
            rest_count_reg    <= '0;
            tone_count_reg    <= '0;
            wave_reg          <= '0;
            div_reg           <= '0;
            pitch_reg         <= '0;
            note_idx_reg      <= '0;
            playing_song_reg  <= bms_pkg::SONG_W'(1);
            previous_song_reg <= bms_pkg::SONG_W'(1);
        end else if (step) begin
            phase_reg         <= phase_next;
            rest_count_reg    <= rest_count_next;
            tone_count_reg    <= tone_count_next;
            wave_reg          <= wave_next;
            div_reg           <= div_next;
            pitch_reg         <= pitch_next;
            note_idx_reg      <= note_idx_next;
            playing_song_reg  <= playing_song_next;
            previous_song_reg <= previous_song_next;
        end
    end

    `BMS_ASSERT_NEXT(a_no_decide_return, phase_reg != bms_pkg::PH_DECIDE, phase_reg != bms_pkg::PH_DECIDE, "sequencer fell back to decide phase")
    `BMS_ASSERT_IMP(a_tone_in_song, phase_reg == bms_pkg::PH_TONE, note_idx_reg < bms_pkg::song_len(playing_song_reg), "sounding note beyond end of song")
    `BMS_ASSERT_IMP(a_wave_in_period, (phase_reg == bms_pkg::PH_TONE) && (div_reg != '0), wave_reg < div_reg, "wave counter outside tone period")
    `BMS_ASSERT_ALWAYS(a_song_valid, (playing_song_reg != '0) && (previous_song_reg != '0), "song register holds zero")

endmodule

/* hw/rtl/bms_out_stage.sv */
// ---------------------------------------------------------------------------
// bms_out_stage
// result register between the sequencer and the output channel
// ---------------------------------------------------------------------------
module bms_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  bms_pkg::result_t  result_in,
    input  logic              m_ready,
    output logic              m_valid,
    output bms_pkg::result_t  result_out,
    output logic              s_ready
);

    logic              valid_reg, valid_next;
    bms_pkg::result_t  data_reg;

    // take a new beat when empty or when the held beat leaves this cycle
    assign s_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result_in;
        end
    end

    assign m_valid    = valid_reg;
    assign result_out = data_reg;

endmodule

/* hw/rtl/buzzer_melody_sequencer.sv */
// ---------------------------------------------------------------------------
// buzzer_melody_sequencer
// plays one of three fixed songs as a square wave, one tone clock tick a beat
// ---------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  s_      | s_valid s_ready s_play_enable           | in
//          | s_song_select                           |
//  m_      | m_valid m_ready m_pwm_level m_tone_on   | out
//          | m_note_number m_note_position           |
//  cfg_    | cfg_we cfg_index cfg_wdata              | in
//
//  one beat in, one beat out; a new beat is taken every cycle unless stalled
//  the result register loads on the accepting edge
//  all per-tick work (score rom, duration multiply, wave compare) sits
//  between the state registers and the result register
//  a held result stalls the input only when m_ready is low
//  reset: synchronous on aresetn low, no clearing pass
// ---------------------------------------------------------------------------
module buzzer_melody_sequencer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_play_enable,
    input  logic [bms_pkg::SONG_W-1:0]     s_song_select,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_pwm_level,
    output logic                           m_tone_on,
    output logic [bms_pkg::PITCH_W-1:0]    m_note_number,
    output logic [bms_pkg::POS_W-1:0]      m_note_position,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [bms_pkg::TICK_W-1:0]     cfg_wdata
);

    logic [bms_pkg::TICK_W-1:0]  unit_ticks_reg, unit_ticks_next;
    logic [bms_pkg::TICK_W-1:0]  rest_ticks_reg, rest_ticks_next;
    bms_pkg::cfg_t               cfg;
    logic                        s_accept;
    bms_pkg::result_t            step_result;
    bms_pkg::result_t            out_result;

    always_comb begin
        unit_ticks_next = unit_ticks_reg;
        rest_ticks_next = rest_ticks_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                bms_pkg::CFG_IDX_UNIT: unit_ticks_next = cfg_wdata;
                bms_pkg::CFG_IDX_REST: rest_ticks_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_ticks_reg <= bms_pkg::TICK_W'(5000000);
            rest_ticks_reg <= bms_pkg::TICK_W'(40000000);
        end else begin
            unit_ticks_reg <= unit_ticks_next;
            rest_ticks_reg <= rest_ticks_next;
        end
    end

    assign cfg.unit_ticks = unit_ticks_reg;
    assign cfg.rest_ticks = rest_ticks_reg;

    assign s_accept = s_valid && s_ready;

    bms_seq_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (s_accept),
        .play_enable (s_play_enable),
        .song_select (s_song_select),
        .cfg         (cfg),
        .result      (step_result)
    );

    bms_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (s_accept),
        .result_in  (step_result),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .result_out (out_result),
        .s_ready    (s_ready)
    );

    assign m_pwm_level     = out_result.pwm_level;
    assign m_tone_on       = out_result.tone_on;
    assign m_note_number   = out_result.note_number;
    assign m_note_position = out_result.note_position;

endmodule

/* bench/buzzer_melody_sequencer_tb.sv */
// ---------------------------------------------------------------------------
// buzzer_melody_sequencer_tb
// drives one tone clock tick per beat, predicts the buzzer drive of every
// tick and compares it field by field with the result channel
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module buzzer_melody_sequencer_tb;
    import bms_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PLAN_ROWS   = 25;

    localparam logic    TYPED  = 1'b1;
    localparam logic    FREE   = 1'b0;
    localparam result_t SILENT = '0;

    typedef struct packed {
        logic    play;
        logic [SONG_W-1:0] sel;
        logic    typed;
        result_t want;
    } step_t;

    // ticks with unit 1 and rest 2; rows marked TYPED carry a hand-read result
    localparam step_t PLAN [PLAN_ROWS] = '{
        {1'b1, 2'd1, TYPED, 1'b1, 1'b1, 4'd1, 6'd0},  // first note of song 1
        {1'b1, 2'd1, FREE, SILENT},
        {1'b1, 2'd1, FREE, SILENT},
        {1'b1, 2'd1, FREE, SILENT},
        {1'b1, 2'd1, TYPED, 1'b1, 1'b1, 4'd2, 6'd1},  // second note
        {1'b1, 2'd1, FREE, SILENT},
        {1'b1, 2'd1, FREE, SILENT},
        {1'b1, 2'd1, FREE, SILENT},
        {1'b0, 2'd1, TYPED, SILENT},                  // play off at a boundary
        {1'b1, 2'd1, FREE, SILENT},
        {1'b1, 2'd0, TYPED, SILENT},                  // select 0 acts as song 3
        {1'b1, 2'd3, FREE, SILENT},
        {1'b1, 2'd0, TYPED, 1'b1, 1'b1, 4'd5, 6'd0},
        {1'b1, 2'd3, FREE, SILENT},
        {1'b1, 2'd3, FREE, SILENT},
        {1'b1, 2'd3, FREE, SILENT},
        {1'b1, 2'd2, TYPED, SILENT},                  // song change mid pass
        {1'b1, 2'd2, FREE, SILENT},
        {1'b1, 2'd2, TYPED, 1'b1, 1'b1, 4'd6, 6'd0},
        {1'b1, 2'd2, FREE, SILENT},
        {1'b1, 2'd2, TYPED, 1'b1, 1'b1, 4'd5, 6'd1},
        {1'b0, 2'd2, FREE, SILENT},
        {1'b0, 2'd3, TYPED, SILENT},
        {1'b1, 2'd1, FREE, SILENT},
        {1'b1, 2'd1, TYPED, SILENT}                   // new song aborts at start
    };

    localparam logic [7:0] SONG1_SCORE [32] = '{
        8'h41, 8'h42, 8'h43, 8'h41, 8'h41, 8'h42, 8'h43, 8'h41,
        8'h43, 8'h44, 8'h85, 8'h43, 8'h44, 8'h85,
        8'h35, 8'h16, 8'h35, 8'h14, 8'h43, 8'h41, 8'h35, 8'h16,
        8'h35, 8'h14, 8'h43, 8'h41,
        8'h41, 8'h48, 8'h81, 8'h41, 8'h48, 8'h81
    };
    // songs 2 and 3 repeat short figures
    localparam logic [7:0] SONG2_FIGURE [6] = '{8'h26, 8'h25, 8'h23, 8'h25, 8'h26, 8'h26};
    localparam logic [7:0] SONG3_FIGURE [7] = '{
        8'h45, 8'h45, 8'h46, 8'h46, 8'h45, 8'h45, 8'h43
    };

    logic                aclk            = 1'b0;
    logic                aresetn         = 1'b0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic                s_play_enable   = 1'b0;
    logic [SONG_W-1:0]   s_song_select   = 2'd1;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic                m_pwm_level;
    logic                m_tone_on;
    logic [PITCH_W-1:0]  m_note_number;
    logic [POS_W-1:0]    m_note_position;
    logic                cfg_we          = 1'b0;
    logic                cfg_index       = CFG_IDX_UNIT;
    logic [TICK_W-1:0]   cfg_wdata       = '0;

    // tb-side tags that travel with each input beat
    logic                beat_typed      = FREE;
    result_t             beat_want       = SILENT;

    // model of the sequencer
    phase_t              seq_phase       = PH_DECIDE;
    logic [TICK_W-1:0]   rest_left       = '0;
    logic [TICK_W-1:0]   tone_left       = '0;
    logic [WAVE_W-1:0]   wave_pos        = '0;
    logic [IDX_W-1:0]    note_idx        = '0;
    logic [SONG_W-1:0]   cur_song        = 2'd1;
    logic [SONG_W-1:0]   last_sel        = 2'd1;
    logic [WAVE_W-1:0]   divisor         = '0;
    logic [TICK_W-1:0]   unit_cfg        = 26'd5000000;
    logic [TICK_W-1:0]   rest_cfg        = 26'd40000000;

    result_t             drive_queue [$];

    int errors        = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asks     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int beats_in      = 0;
    int notes_started = 0;
    int notes_capped  = 0;
    int rests_started = 0;
    int low_ticks     = 0;

    buzzer_melody_sequencer uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_play_enable   (s_play_enable),
        .s_song_select   (s_song_select),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pwm_level     (m_pwm_level),
        .m_tone_on       (m_tone_on),
        .m_note_number   (m_note_number),
        .m_note_position (m_note_position),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] score_byte(input logic [SONG_W-1:0] song,
                                              input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        case (song)
            2'd1: begin
                b = SONG1_SCORE[idx[4:0]];
            end
            2'd2: begin
                b = SONG2_FIGURE[idx % 7'd6];
            end
            default: begin
                b = SONG3_FIGURE[idx % 7'd7];
            end
        endcase
        return b;
    endfunction

    task automatic start_rest();
        seq_phase = PH_REST;
        rest_left = (rest_cfg != '0) ? rest_cfg : TICK_ONE;
        rests_started++;
    endtask

    task automatic note_edge(input logic en, input logic [SONG_W-1:0] sel);
        logic [IDX_W-1:0]  last_note;
        logic [7:0]        w;
        logic [PROD_W-1:0] span;
        case (cur_song)
            2'd1:    last_note = 7'd32;
            2'd2:    last_note = 7'd64;
            default: last_note = 7'd28;
        endcase
        if (note_idx >= last_note || !en) begin
            start_rest();
        end else if (sel != last_sel) begin
            last_sel = sel;
            start_rest();
        end else begin
            w = score_byte(cur_song, note_idx);
            span = w[7:4] * unit_cfg;
            if (span > PROD_W'(TICK_MAX)) begin
                span = PROD_W'(TICK_MAX);
                notes_capped++;
            end
            if (span == '0) begin
                span = PROD_W'(1);
            end
            tone_left = span[TICK_W-1:0];
            case (w[3:0])
                4'd1:    divisor = 16'd38223;
                4'd2:    divisor = 16'd34052;
                4'd3:    divisor = 16'd30338;
                4'd4:    divisor = 16'd28635;
                4'd5:    divisor = 16'd25511;
                4'd6:    divisor = 16'd22728;
                4'd7:    divisor = 16'd20249;
                4'd8:    divisor = 16'd51021;
                default: divisor = 16'd0;
            endcase
            wave_pos = '0;
            seq_phase = PH_TONE;
            notes_started++;
        end
    endtask

    task automatic pass_begin(input logic en, input logic [SONG_W-1:0] sel);
        if (!en) begin
            start_rest();
        end else begin
            cur_song = sel;
            note_idx = '0;
            note_edge(en, sel);
        end
    endtask

    // advances the model by one tick and returns the buzzer drive for it
    task automatic next_drive(input logic en, input logic [SONG_W-1:0] sel_in,
                              output result_t r);
        logic [SONG_W-1:0] sel;
        logic [7:0]        w;
        sel = (sel_in == 2'd0) ? SONG_FALLBACK : sel_in;
        case (seq_phase)
            PH_TONE: begin
                if (tone_left == '0) begin
                    note_idx = note_idx + 7'd1;
                    note_edge(en, sel);
                end
            end
            PH_REST: begin
                if (rest_left == '0) begin
                    seq_phase = PH_DECIDE;
                    pass_begin(en, sel);
                end
            end
            default: begin
                pass_begin(en, sel);
            end
        endcase
        r = SILENT;
        if (seq_phase == PH_TONE) begin
            w = score_byte(cur_song, note_idx);
            r.pwm_level     = (wave_pos < (divisor >> 1));
            r.tone_on       = 1'b1;
            r.note_number   = w[3:0];
            r.note_position = note_idx[POS_W-1:0];
            if (!r.pwm_level) begin
                low_ticks++;
            end
            wave_pos = wave_pos + 16'd1;
            if (wave_pos >= divisor) begin
                wave_pos = '0;
            end
            tone_left = tone_left - TICK_ONE;
        end else begin
            rest_left = rest_left - TICK_ONE;
        end
    endtask

    always @(posedge aclk) begin : track_beats
        result_t got;
        result_t want;
        result_t guess;
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (aresetn && m_valid && m_ready) begin
            got = {m_pwm_level, m_tone_on, m_note_number, m_note_position};
            if (drive_queue.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: result beat with nothing expected", $time);
                end
            end else begin
                want = drive_queue.pop_front();
                if (got.pwm_level !== want.pwm_level || got.tone_on !== want.tone_on ||
                    got.note_number !== want.note_number ||
                    got.note_position !== want.note_position) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("%0t: exp pwm %0b tone %0b note %0d pos %0d", $time,
                                 want.pwm_level, want.tone_on, want.note_number,
                                 want.note_position);
                        $display("%0t: got pwm %0b tone %0b note %0d pos %0d", $time,
                                 got.pwm_level, got.tone_on, got.note_number,
                                 got.note_position);
                    end
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            next_drive(s_play_enable, s_song_select, guess);
            drive_queue.push_back(beat_typed ? beat_want : guess);
            beats_in++;
        end
    end

    // receiver: random back-pressure plus an occasional long hold
    always @(posedge aclk) begin
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
        end
        $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_beat(input logic play, input logic [SONG_W-1:0] sel,
                             input logic typed, input result_t want);
        int gap;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_play_enable <= play;
        s_song_select <= sel;
        beat_typed    <= typed;
        beat_want     <= want;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (drive_queue.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // drives one write, then holds cfg_we low before returning so back-to-back writes never collide
    task automatic write_reg(input logic idx, input logic [TICK_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_IDX_UNIT) begin
            unit_cfg = val;
        end else begin
            rest_cfg = val;
        end
        @(posedge aclk);
    endtask

    // mostly steady playing with random song changes and play-off stretches
    task automatic random_phase(input int beats, input int hold_at);
        int k;
        int roll;
        logic on;
        logic [SONG_W-1:0] pick;
        on = 1'b1;
        pick = 2'($urandom_range(1, 3));
        for (k = 0; k < beats; k++) begin
            if (k == hold_at) begin
                hold_asks++;
            end
            roll = $urandom_range(99);
            if (roll < 4) begin
                pick = 2'($urandom_range(0, 3));
            end else if (on && roll < 7) begin
                on = 1'b0;
            end else if (!on && roll < 40) begin
                on = 1'b1;
            end
            if (roll >= 92) begin
                send_beat(1'($urandom_range(1)), 2'($urandom_range(3)), FREE, SILENT);
            end else begin
                send_beat(on, pick, FREE, SILENT);
            end
        end
    endtask

    initial begin
        int i;
        int n;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 13;
        recv_idle_pct = 58;
        write_reg(CFG_IDX_UNIT, 26'd1);
        write_reg(CFG_IDX_REST, 26'd2);
        for (i = 0; i < PLAN_ROWS; i++) begin
            send_beat(PLAN[i].play, PLAN[i].sel, PLAN[i].typed, PLAN[i].want);
        end

        drain_results();
        write_reg(CFG_IDX_UNIT, 26'd1);
        write_reg(CFG_IDX_REST, 26'd1);
        random_phase(160, 60);

        // zero lengths last one tick
        drain_results();
        send_idle_pct = 58;
        recv_idle_pct = 13;
        write_reg(CFG_IDX_UNIT, 26'd0);
        write_reg(CFG_IDX_REST, 26'd0);
        random_phase(160, -1);

        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_IDX_UNIT, 26'd2);
        write_reg(CFG_IDX_REST, 26'd3);
        random_phase(160, -1);

        // next note boundary hits the length cap
        drain_results();
        write_reg(CFG_IDX_UNIT, TICK_MAX);
        n = 0;
        while (notes_capped == 0 && n < 200) begin
            send_beat(1'b1, 2'd3, FREE, SILENT);
            n++;
        end
        for (i = 0; i < 16; i++) begin
            send_beat(1'($urandom_range(1)), 2'($urandom_range(3)), FREE, SILENT);
        end
        drain_results();
        write_reg(CFG_IDX_REST, TICK_MAX);

        repeat (4) @(posedge aclk);
        if (drive_queue.size() != 0) begin
            errors++;
        end
        $display("ran %0d ticks: %0d notes (%0d length-capped), %0d rests, %0d low-wave ticks",
                 beats_in, notes_started, notes_capped, rests_started, low_ticks);
        $display("unit and rest lengths from zero to full scale, all select codes, %0d errors",
                 errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
